@@ src/time_ordered_event_queue_unit_macros.svh @@
// assertion macros for the event queue rtl
// no dependencies; included by the top level, which carries the concurrent checks
`ifndef TIME_ORDERED_EVENT_QUEUE_UNIT_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define TOEQ_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("event queue check failed: invariant");

// consequent holds in the same cycle as the antecedent
`define TOEQ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event queue check failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define TOEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event queue check failed: next-cycle implication");

`endif

@@ src/toeq_pkg.sv @@
// shared types, codes and defaults for the time-ordered event queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 32;

    localparam int FIELD_TIME_W = 32;
    localparam int OCC_W        = 7;
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 120;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [7:0]  kind;
        logic [9:0]  owner;
        logic [7:0]  port;
        logic [15:0] handle;
    } payload_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic     eval;
        cell_op_t op;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/toeq_cell.sv @@
// one slot of the sorted event chain: stored event, compare flags, neighbor moves
// depends on toeq_pkg
`timescale 1ns / 1ps
`default_nettype none

module toeq_cell
    import toeq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctl_t            ctl,
    input  wire logic                 occupied,
    input  wire logic [TIME_BITS-1:0] key_time,
    input  wire logic [15:0]          key_handle,
    input  wire logic [TIME_BITS-1:0] new_time,
    input  wire payload_t             new_payload,
    input  wire logic [TIME_BITS-1:0] left_time,
    input  wire payload_t             left_payload,
    input  wire logic                 left_le,
    input  wire logic [TIME_BITS-1:0] right_time,
    input  wire payload_t             right_payload,
    input  wire logic                 pre_hit,
    output logic [TIME_BITS-1:0]      slot_time,
    output payload_t                  slot_payload,
    output logic                      le,
    output logic                      match
);

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    payload_t             payload_reg;
    payload_t             payload_next;
    logic                 le_reg;
    logic                 match_reg;

    always_comb
    begin
        time_next    = time_reg;
        payload_next = payload_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // keep if at or before the key, take the new event at the boundary, else the left neighbor's
                if (!le_reg)
                begin
                    if (left_le)
                    begin
                        time_next    = new_time;
                        payload_next = new_payload;
                    end
                    else
                    begin
                        time_next    = left_time;
                        payload_next = left_payload;
                    end
                end
            end
            CELL_SHIFT:
            begin
                time_next    = right_time;
                payload_next = right_payload;
            end
            CELL_REMOVE:
            begin
                if (pre_hit)
                begin
                    time_next    = right_time;
                    payload_next = right_payload;
                end
            end
            default:
            begin
                time_next    = time_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        payload_reg <= payload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctl.eval)
        begin
            le_reg    <= occupied && (time_reg <= key_time);
            match_reg <= occupied && (payload_reg.handle == key_handle);
        end
    end

    assign slot_time    = time_reg;
    assign slot_payload = payload_reg;
    assign le           = le_reg;
    assign match        = match_reg;

endmodule

`default_nettype wire

@@ src/toeq_prefix.sv @@
// log-depth prefix or over the cancel hit flags and first-hit one-hot
// depends on toeq_pkg
`timescale 1ns / 1ps
`default_nettype none

module toeq_prefix
    import toeq_pkg::*;
#(
    parameter int N = DEF_QUEUE_DEPTH
) (
    input  wire logic [N-1:0] hit,
    output logic [N-1:0]      pre,
    output logic [N-1:0]      first
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] stage [LEVELS+1];

    always_comb
    begin
        stage[0] = hit;
        for (int s = 0; s < LEVELS; s++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << s))
                    stage[s+1][i] = stage[s][i] | stage[s][i - (1 << s)];
                else
                    stage[s+1][i] = stage[s][i];
            end
        end
    end

    assign pre   = stage[LEVELS];
    assign first = hit & ~(stage[LEVELS] << 1);

endmodule

`default_nettype wire

@@ src/time_ordered_event_queue_unit.sv @@
// time-ordered event queue: top level with control, output register and cell chain
// depends on toeq_pkg, toeq_cell, toeq_prefix and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "time_ordered_event_queue_unit_macros.svh"

// usage
// - input channel s_*: one operation per item, tuser carries the mode
//   (insert, pop, cancel by handle), tdata the event fields
// - output channel m_*: exactly one result item per input item, in order,
//   tuser carries the status, tdata the event, current time and occupancy
// - the events sit in a chain of QUEUE_DEPTH cells sorted by time, earliest
//   in cell 0; equal times keep arrival order
// - timing: at the accept edge every cell compares its stored time and
//   handle against the key; at the move edge, once the output register is
//   free, the whole chain moves one step (shift in, shift out or close a
//   gap) and the result register loads; ready returns in the cycle after that
// - one item at a time, set by the compare-then-move order of the cells: a
//   new item is accepted only after the move step of the last; the result is
//   valid from the move edge on
// - if the receiver stalls, the finished result holds in the output register
//   and one more item is still accepted; its move step waits until the
//   output register is free
// - reset clears occupancy and simulation time; slot contents need no
//   clearing since only occupied cells are ever compared or read

module time_ordered_event_queue_unit
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // event_time[31:0], event_kind[39:32], owner_id[49:40], port_id[57:50],
    // handle[73:58], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_time[31:0], out_kind[39:32], out_owner[49:40], out_port[57:50],
    // out_handle[73:58], current_time[105:74], occupancy[112:106], zero fill above
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [1:0]                  m_tuser
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t state_reg;

    // latched operation
    logic [1:0]           mode_reg;
    logic [TIME_BITS-1:0] new_time_reg;
    payload_t             new_pay_reg;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [TIME_BITS-1:0] sim_time_reg;
    logic [TIME_BITS-1:0] sim_time_next;

    // output register
    logic                 m_tvalid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [TIME_BITS-1:0] ev_time_reg;
    logic [TIME_BITS-1:0] ev_time_next;
    payload_t             ev_pay_reg;
    payload_t             ev_pay_next;
    logic [TIME_BITS-1:0] cur_time_reg;
    logic [CW-1:0]        occ_reg;

    // input unpack
    logic [TIME_BITS-1:0] in_time;
    payload_t             in_pay;

    // chain signals
    logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
    payload_t             cell_pay  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le_vec;
    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] occ_vec;
    logic [QUEUE_DEPTH-1:0] pre_vec;
    logic [QUEUE_DEPTH-1:0] first_hot;

    logic                 accept;
    logic                 apply_go;
    cell_op_t             op_sel;
    cell_ctl_t            ctl;

    // cancel result gathered through the first-hit one-hot
    logic [TIME_BITS-1:0] hit_time;
    payload_t             hit_pay;

    assign in_time       = TIME_BITS'(s_tdata[31:0]);
    assign in_pay.kind   = s_tdata[39:32];
    assign in_pay.owner  = s_tdata[49:40];
    assign in_pay.port   = s_tdata[57:50];
    assign in_pay.handle = s_tdata[73:58];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign apply_go = (state_reg == S_APPLY) && (!m_tvalid_reg || m_tready);

    assign ctl.eval = accept;
    assign ctl.op   = apply_go ? op_sel : CELL_HOLD;

    // cell chain
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_cell
        logic [TIME_BITS-1:0] l_time;
        payload_t             l_pay;
        logic                 l_le;
        logic [TIME_BITS-1:0] r_time;
        payload_t             r_pay;

        assign occ_vec[gi] = (CW'(gi) < count_reg);

        if (gi == 0)
        begin : g_head
            // head has no left neighbor: the new event lands here when nothing precedes it
            assign l_time = new_time_reg;
            assign l_pay  = new_pay_reg;
            assign l_le   = 1'b1;
        end
        else
        begin : g_mid
            assign l_time = cell_time[gi-1];
            assign l_pay  = cell_pay[gi-1];
            assign l_le   = le_vec[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1)
        begin : g_tail
            // tail falls off the occupied range when the chain moves left
            assign r_time = cell_time[gi];
            assign r_pay  = cell_pay[gi];
        end
        else
        begin : g_body
            assign r_time = cell_time[gi+1];
            assign r_pay  = cell_pay[gi+1];
        end

        toeq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .occupied      (occ_vec[gi]),
            .key_time      (in_time),
            .key_handle    (in_pay.handle),
            .new_time      (new_time_reg),
            .new_payload   (new_pay_reg),
            .left_time     (l_time),
            .left_payload  (l_pay),
            .left_le       (l_le),
            .right_time    (r_time),
            .right_payload (r_pay),
            .pre_hit       (pre_vec[gi]),
            .slot_time     (cell_time[gi]),
            .slot_payload  (cell_pay[gi]),
            .le            (le_vec[gi]),
            .match         (match_vec[gi])
        );
    end

    toeq_prefix #(
        .N (QUEUE_DEPTH)
    ) u_prefix (
        .hit   (match_vec),
        .pre   (pre_vec),
        .first (first_hot)
    );

    always_comb
    begin
        hit_time = '0;
        hit_pay  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (first_hot[i])
            begin
                hit_time = hit_time | cell_time[i];
                hit_pay  = hit_pay | cell_pay[i];
            end
        end
    end

    // operation decode for the move step
    always_comb
    begin
        op_sel        = CELL_HOLD;
        status_next   = STAT_OK;
        ev_time_next  = '0;
        ev_pay_next   = '0;
        count_next    = count_reg;
        sim_time_next = sim_time_reg;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (count_reg >= CW'(QUEUE_DEPTH))
                    status_next = STAT_FULL;
                else
                begin
                    op_sel     = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_POP:
            begin
                if (count_reg == '0)
                    status_next = STAT_EMPTY;
                else
                begin
                    op_sel        = CELL_SHIFT;
                    ev_time_next  = cell_time[0];
                    ev_pay_next   = cell_pay[0];
                    sim_time_next = cell_time[0];
                    count_next    = count_reg - CW'(1);
                end
            end
            MODE_CANCEL:
            begin
                if (match_vec == '0)
                    status_next = STAT_NOT_FOUND;
                else
                begin
                    op_sel       = CELL_REMOVE;
                    ev_time_next = hit_time;
                    ev_pay_next  = hit_pay;
                    count_next   = count_reg - CW'(1);
                end
            end
            default:
            begin
                // unused mode: report time and occupancy only
                op_sel = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            sim_time_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (apply_go)
                    begin
                        state_reg    <= S_IDLE;
                        count_reg    <= count_next;
                        sim_time_reg <= sim_time_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (apply_go)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= s_tuser;
            new_time_reg <= in_time;
            new_pay_reg  <= in_pay;
        end
        if (apply_go)
        begin
            status_reg   <= status_next;
            ev_time_reg  <= ev_time_next;
            ev_pay_reg   <= ev_pay_next;
            cur_time_reg <= sim_time_next;
            occ_reg      <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {
        7'd0,
        OCC_W'(occ_reg),
        FIELD_TIME_W'(cur_time_reg),
        ev_pay_reg.handle,
        ev_pay_reg.port,
        ev_pay_reg.owner,
        ev_pay_reg.kind,
        FIELD_TIME_W'(ev_time_reg)
    };

    // checks
    `TOEQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(QUEUE_DEPTH))
    `TOEQ_ASSERT_IMPLIES(a_le_thermometer, clk, rst_n, state_reg == S_APPLY,
        ((le_vec + QUEUE_DEPTH'(1)) & le_vec) == '0)
    `TOEQ_ASSERT_ALWAYS(a_single_cancel_hit, clk, rst_n, $onehot0(first_hot))
    `TOEQ_ASSERT_IMPLIES(a_empty_no_hit, clk, rst_n,
        state_reg == S_APPLY && count_reg == '0, match_vec == '0)
    `TOEQ_ASSERT_NEXT(a_apply_gives_result, clk, rst_n, apply_go, m_tvalid && s_tready)

endmodule

`default_nettype wire

@@ sim/toeq_event_checker.sv @@
// result checker for the time-ordered event queue: watches both streams, keeps
// its own sorted copy of the queued events and compares every result item
// depends on toeq_pkg
`timescale 1ns / 1ps

module toeq_event_checker
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [1:0]             m_tuser,
    output int                          mismatch_count,
    output int                          pending_count
);

    typedef struct packed {
        logic [FIELD_TIME_W-1:0] at;
        payload_t                info;
    } queued_event_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [FIELD_TIME_W-1:0] ev_time;
        payload_t                info;
        logic [FIELD_TIME_W-1:0] now;
        logic [OCC_W-1:0]        occ;
    } op_result_t;

    queued_event_t           sorted_events[$];
    op_result_t              awaited_results[$];
    logic [FIELD_TIME_W-1:0] model_now  = '0;
    int                      mismatches = 0;

    assign mismatch_count = mismatches;

    // one queue operation on the local copy, returns the result it must produce
    function automatic op_result_t run_queue_op(logic [1:0] mode,
                                                logic [FIELD_TIME_W-1:0] at,
                                                payload_t info);
        op_result_t    res;
        queued_event_t ev;
        int            pos;
        res        = '0;
        res.status = STAT_OK;
        pos        = 0;
        case (mode)
            MODE_INSERT:
                if (sorted_events.size() >= QUEUE_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    // stable: goes behind every event with an equal or earlier time
                    while (pos < sorted_events.size() && sorted_events[pos].at <= at)
                        pos++;
                    ev.at   = at;
                    ev.info = info;
                    sorted_events.insert(pos, ev);
                end
            MODE_POP:
                if (sorted_events.size() == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.ev_time = sorted_events[0].at;
                    res.info    = sorted_events[0].info;
                    // may move backward when the head is older than the current time
                    model_now   = sorted_events[0].at;
                    sorted_events.delete(0);
                end
            MODE_CANCEL:
            begin
                while (pos < sorted_events.size() &&
                       sorted_events[pos].info.handle != info.handle)
                    pos++;
                if (pos == sorted_events.size())
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    res.ev_time = sorted_events[pos].at;
                    res.info    = sorted_events[pos].info;
                    sorted_events.delete(pos);
                end
            end
            default:
                ;
        endcase
        res.now = model_now;
        res.occ = OCC_W'(sorted_events.size());
        return res;
    endfunction

    task automatic check_field(string name, logic [FIELD_TIME_W-1:0] want,
                               logic [FIELD_TIME_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t result %s mismatch: expected %0h, got %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        payload_t   in_info;
        op_result_t want;
        if (!rst_n)
        begin
            sorted_events.delete();
            awaited_results.delete();
            model_now     = '0;
            pending_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_info = {s_tdata[39:32], s_tdata[49:40], s_tdata[57:50], s_tdata[73:58]};
                awaited_results.push_back(run_queue_op(s_tuser, s_tdata[31:0], in_info));
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t result item with nothing pending, tuser %0h tdata %0h",
                                 $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", FIELD_TIME_W'(want.status),
                                FIELD_TIME_W'(m_tuser));
                    check_field("out_time", want.ev_time, m_tdata[31:0]);
                    check_field("out_kind", FIELD_TIME_W'(want.info.kind),
                                FIELD_TIME_W'(m_tdata[39:32]));
                    check_field("out_owner", FIELD_TIME_W'(want.info.owner),
                                FIELD_TIME_W'(m_tdata[49:40]));
                    check_field("out_port", FIELD_TIME_W'(want.info.port),
                                FIELD_TIME_W'(m_tdata[57:50]));
                    check_field("out_handle", FIELD_TIME_W'(want.info.handle),
                                FIELD_TIME_W'(m_tdata[73:58]));
                    check_field("current_time", want.now, m_tdata[105:74]);
                    check_field("occupancy", FIELD_TIME_W'(want.occ),
                                FIELD_TIME_W'(m_tdata[112:106]));
                end
            end
            pending_count <= awaited_results.size();
        end
    end

endmodule

@@ sim/time_ordered_event_queue_unit_tb.sv @@
// testbench top for the time-ordered event queue: clock, reset, operation
// stimulus, receiver back-pressure, watchdog and verdict
// depends on toeq_pkg, toeq_event_checker and the block itself
`timescale 1ns / 1ps

module time_ordered_event_queue_unit_tb;
    import toeq_pkg::*;

    // mode 3 is not a defined operation, the block must report and do nothing
    localparam logic [1:0] MODE_NOP = 2'd3;

    // random segment flavors
    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIXED = 2;
    localparam int SEG_NOISE = 3;

    localparam int TOTAL_ITEMS = 1450;
    // receiver hold-off that backs up the block
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 500;
    // the limit lies far above the hold-off above, so the long receiver stall
    // alone does not trip the watchdog
    localparam int IDLE_LIMIT  = 2000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    int mismatch_count;
    int pending_count;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    time_ordered_event_queue_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    toeq_event_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // offer one operation and hold it until accepted; the sender runs in
    // bursts of random length with random gaps between them
    task automatic push_op(logic [1:0] mode, logic [31:0] at, logic [7:0] kind,
                           logic [9:0] owner, logic [7:0] port, logic [15:0] hnd);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, hnd, port, owner, kind, at};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    // times: mostly a narrow range so that ties are common, plus both ends
    // of the range and fully random values
    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       return $urandom_range(0, 3);
            2:       return $urandom();
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    // handles: a small pool so that cancels hit and duplicates occur,
    // sometimes a full-width value that almost never matches
    function automatic logic [15:0] pick_handle();
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(0, 15));
        return 16'($urandom());
    endfunction

    // receiver: stretches of always ready, light, heavy and random stalls,
    // and once a long hold-off so that the output backs up and the block stops taking items
    initial
    begin : receiver
        int  style;
        int  stretch;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && items_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk) m_tready <= 1'b0;
            end
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(5, 40);
            repeat (stretch)
            begin
                @(posedge clk);
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // watchdog: ends the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         seg;
        int         style;
        int         seg_len;
        int         roll;
        logic [1:0] mode;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue cases and the unused mode
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_CANCEL, 32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_NOP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        // all-zero and all-one fields
        push_op(MODE_INSERT, 32'd100, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_INSERT, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 8'hFF, 16'hFFFF);
        push_op(MODE_INSERT, 32'd0, 8'h5A, 10'h155, 8'hA5, 16'h0001);
        // equal times must keep arrival order
        push_op(MODE_INSERT, 32'd100, 8'h11, 10'h022, 8'h33, 16'h0002);
        push_op(MODE_INSERT, 32'd100, 8'h44, 10'h055, 8'h66, 16'h0003);
        // duplicate handle placed ahead of the earlier one
        push_op(MODE_INSERT, 32'd50, 8'h77, 10'h088, 8'h99, 16'h0002);
        // cancel takes the first match from the head
        push_op(MODE_CANCEL, 32'd0, 8'h00, 10'h000, 8'h00, 16'h0002);
        push_op(MODE_CANCEL, 32'd0, 8'h00, 10'h000, 8'h00, 16'hFFFF);
        push_op(MODE_CANCEL, 32'd0, 8'h00, 10'h000, 8'h00, 16'h1234);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        // pop then insert an older event: the clock goes backward on its pop
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_INSERT, 32'd7, 8'hC3, 10'h2AA, 8'h3C, 16'h0005);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_NOP,    32'hFFFF_FFFF, 8'hFF, 10'h3FF, 8'hFF, 16'hFFFF);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        // largest time reaches the clock, a cancel leaves the clock alone
        push_op(MODE_INSERT, 32'hFFFF_FFFF, 8'h01, 10'h001, 8'h01, 16'h0009);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);
        push_op(MODE_INSERT, 32'd0, 8'h02, 10'h002, 8'h02, 16'h000A);
        push_op(MODE_CANCEL, 32'd0, 8'h00, 10'h000, 8'h00, 16'h000A);
        push_op(MODE_POP,    32'd0, 8'h00, 10'h000, 8'h00, 16'h0000);

        // random: a long fill to reach a full queue, a long drain to empty it,
        // then segments of random flavor and length
        seg = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            style   = (seg < 2) ? seg : $urandom_range(SEG_FILL, SEG_NOISE);
            seg_len = (seg < 2) ? 120 : $urandom_range(20, 90);
            seg++;
            repeat (seg_len)
            begin
                roll = $urandom_range(0, 99);
                case (style)
                    SEG_FILL:
                        mode = (roll < 85) ? MODE_INSERT : (roll < 95) ? MODE_POP : MODE_CANCEL;
                    SEG_DRAIN:
                        mode = (roll < 15) ? MODE_INSERT : (roll < 75) ? MODE_POP : MODE_CANCEL;
                    SEG_MIXED:
                        mode = (roll < 45) ? MODE_INSERT : (roll < 80) ? MODE_POP : MODE_CANCEL;
                    default:
                        mode = 2'($urandom_range(0, 3));
                endcase
                push_op(mode, pick_time(), 8'($urandom()), 10'($urandom()),
                        8'($urandom()), pick_handle());
            end
        end
        s_tvalid <= 1'b0;

        // drain: let the checker see the last acceptance, wait for every
        // result, then keep watching for anything unexpected
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
